// ----- sv/i2a_pkg.sv -----
`default_nettype none
package i2a_pkg;

	localparam int CMD_W = 3;
	localparam int VAL_W = 32;
	localparam int CHR_W = 8;

	// ten BCD digits hold any 32-bit magnitude; octal needs 33 bits
	localparam int DIG_W = 40;
	localparam int BCD_DIGITS = DIG_W / 4;

	localparam logic [CMD_W-1:0] CMD_LIT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RAW  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SDEC = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UDEC = 3'd3;
	localparam logic [CMD_W-1:0] CMD_HEX  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_OCT  = 3'd5;

	localparam logic [CHR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHR_W-1:0] CH_A     = 8'h41;

	localparam logic [3:0] DEC_DIGITS = 4'd10;
	localparam logic [3:0] HEX_DIGITS = 4'd8;
	localparam logic [3:0] OCT_DIGITS = 4'd11;

	typedef enum logic [1:0] {
		DM_DEC = 2'd0,
		DM_HEX = 2'd1,
		DM_OCT = 2'd2
	} dig_mode_t;

	typedef struct packed {
		logic      load;
		logic      step;
		dig_mode_t mode;
	} dig_ctrl_t;

	typedef struct packed {
		logic [3:0] digit;
		logic       emit;
		logic       last;
	} dig_stat_t;

	function automatic logic [CHR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHR_W-1:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = CH_A + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- sv/i2a_req_if.sv -----
`default_nettype none
interface i2a_req_if;
	import i2a_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [VAL_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

// ----- sv/i2a_chr_if.sv -----
`default_nettype none
interface i2a_chr_if;
	import i2a_pkg::*;

	logic             valid;
	logic             ready;
	logic [CHR_W-1:0] out_char;
	logic             last;

	modport source (output valid, output out_char, output last, input ready);
	modport sink (input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

// ----- sv/integer_to_ascii_formatter.sv -----
`default_nettype none
// Integer to ASCII formatter.
// The request channel carries one word per request: a command and a 32-bit
// value. The text channel returns the formatted characters most significant
// first, one word per character, with last set on the final one.
// Commands: literal char (newline becomes newline plus carriage return),
// raw char, signed decimal, unsigned decimal, hex with "0x", octal with "0".
// Commands 6 and 7 are accepted and produce no characters.
// One request is worked at a time; request.ready is high only between
// requests. Hex and octal digits stream from a shift register, one digit
// per cycle unless the text channel stalls, with leading zeros skipped
// (8 or 11 digit slots). Decimal first runs a bit-serial binary-to-BCD
// converter, then walks 10 digit slots. Commands 6 and 7 leave the request
// side ready. The output register holds one finished character; a stalled
// receiver holds the block in place and nothing is lost. Reset clears the
// state machine and the output valid; no clearing pass is needed.
module integer_to_ascii_formatter (
	input  wire logic clk,
	input  wire logic arst_n,
	i2a_req_if.sink   request,
	i2a_chr_if.source text
);
	import i2a_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CHAR   = 8'b0000_0010,
		S_CR     = 8'b0000_0100,
		S_SIGN   = 8'b0000_1000,
		S_PFX0   = 8'b0001_0000,
		S_PFXX   = 8'b0010_0000,
		S_CONV   = 8'b0100_0000,
		S_DIGITS = 8'b1000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [CMD_W-1:0] cmd_q;
	logic [VAL_W-1:0] val_q, val_d;
	logic             req_take;
	logic             neg_in;

	logic             out_valid_q;
	logic [CHR_W-1:0] out_char_q;
	logic             out_last_q;
	logic             slot_free;
	logic             push;
	logic [CHR_W-1:0] push_char;
	logic             push_last;

	logic             conv_start;
	logic [VAL_W-1:0] conv_bin;
	logic             conv_done;
	logic [DIG_W-1:0] conv_bcd;

	dig_ctrl_t        dctrl;
	dig_stat_t        dstat;
	logic [DIG_W-1:0] dig_data;

	assign request.ready = (state_q == S_IDLE);
	assign req_take      = request.valid && request.ready;
	assign neg_in        = request.value[VAL_W-1];

	// the output slot takes a new word when empty or being drained
	assign slot_free = !out_valid_q || text.ready;

	// negate once at accept so the converter always sees a magnitude
	assign val_d = (request.command == CMD_SDEC && neg_in) ? (VAL_W'(0) - request.value)
		: request.value;

	assign conv_bin = (state_q == S_IDLE) ? val_d : val_q;

	always_comb begin
		state_d    = state_q;
		push       = 1'b0;
		push_char  = '0;
		push_last  = 1'b0;
		conv_start = 1'b0;
		dctrl.load = 1'b0;
		dctrl.step = 1'b0;
		dctrl.mode = DM_DEC;
		dig_data   = conv_bcd;
		case (state_q)
			S_IDLE: begin
				if (req_take) begin
					case (request.command)
						CMD_LIT, CMD_RAW: state_d = S_CHAR;
						CMD_SDEC: begin
							if (neg_in) begin
								state_d = S_SIGN;
							end else begin
								conv_start = 1'b1;
								state_d    = S_CONV;
							end
						end
						CMD_UDEC: begin
							conv_start = 1'b1;
							state_d    = S_CONV;
						end
						CMD_HEX, CMD_OCT: state_d = S_PFX0;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CHAR: begin
				if (slot_free) begin
					push      = 1'b1;
					push_char = val_q[CHR_W-1:0];
					if (cmd_q == CMD_LIT && val_q[CHR_W-1:0] == CH_LF) begin
						state_d = S_CR;
					end else begin
						push_last = 1'b1;
						state_d   = S_IDLE;
					end
				end
			end
			S_CR: begin
				if (slot_free) begin
					push      = 1'b1;
					push_char = CH_CR;
					push_last = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_SIGN: begin
				if (slot_free) begin
					push       = 1'b1;
					push_char  = CH_MINUS;
					conv_start = 1'b1;
					state_d    = S_CONV;
				end
			end
			S_PFX0: begin
				if (slot_free) begin
					push      = 1'b1;
					push_char = CH_ZERO;
					if (cmd_q == CMD_HEX) begin
						state_d = S_PFXX;
					end else if (val_q == '0) begin
						// octal zero: the prefix digit stands alone
						push_last = 1'b1;
						state_d   = S_IDLE;
					end else begin
						dctrl.load = 1'b1;
						dctrl.mode = DM_OCT;
						dig_data   = {1'b0, val_q, 7'b0};
						state_d    = S_DIGITS;
					end
				end
			end
			S_PFXX: begin
				if (slot_free) begin
					push       = 1'b1;
					push_char  = CH_X;
					dctrl.load = 1'b1;
					dctrl.mode = DM_HEX;
					dig_data   = {val_q, 8'b0};
					state_d    = S_DIGITS;
				end
			end
			S_CONV: begin
				if (conv_done) begin
					dctrl.load = 1'b1;
					dctrl.mode = DM_DEC;
					dig_data   = conv_bcd;
					state_d    = S_DIGITS;
				end
			end
			S_DIGITS: begin
				if (!dstat.emit) begin
					// skip a leading zero without using the slot
					dctrl.step = 1'b1;
				end else if (slot_free) begin
					dctrl.step = 1'b1;
					push       = 1'b1;
					push_char  = digit_char(dstat.digit);
					push_last  = dstat.last;
					if (dstat.last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the request operands and the output word
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q <= request.command;
			val_q <= val_d;
		end
		if (push) begin
			out_char_q <= push_char;
			out_last_q <= push_last;
		end
	end

	i2a_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.bin    (conv_bin),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	i2a_digits u_digits (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dctrl),
		.data   (dig_data),
		.stat   (dstat)
	);

	assign text.valid    = out_valid_q;
	assign text.out_char = out_char_q;
	assign text.last     = out_last_q;
endmodule
`default_nettype wire

// ----- sv/i2a_bcd.sv -----
`default_nettype none
module i2a_bcd (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [i2a_pkg::VAL_W-1:0] bin,
	output logic                         done,
	output logic [i2a_pkg::DIG_W-1:0]    bcd
);
	import i2a_pkg::*;

	localparam int CNT_W = $clog2(VAL_W + 1);

	logic [VAL_W-1:0] bin_q;
	logic [DIG_W-1:0] bcd_q;
	logic [DIG_W-1:0] adj;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	// add-3 correction on every nibble before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(VAL_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
			bcd_q <= {adj[DIG_W-2:0], bin_q[VAL_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;
endmodule
`default_nettype wire

// ----- sv/i2a_digits.sv -----
`default_nettype none
module i2a_digits (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire i2a_pkg::dig_ctrl_t      ctrl,
	input  wire logic [i2a_pkg::DIG_W-1:0] data,
	output i2a_pkg::dig_stat_t           stat
);
	import i2a_pkg::*;

	logic [DIG_W-1:0] dig_q;
	logic [3:0]       cnt_q;
	logic             oct_q;
	logic             started_q;
	logic [3:0]       digit;
	logic             emit;

	// top digit sits at the left end of the register
	assign digit = oct_q ? {1'b0, dig_q[DIG_W-1 -: 3]} : dig_q[DIG_W-1 -: 4];
	// drop leading zeros, but always show the final digit
	assign emit  = started_q || (digit != 4'd0) || (cnt_q == 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			started_q <= 1'b0;
			oct_q     <= 1'b0;
		end else if (ctrl.load) begin
			started_q <= 1'b0;
			oct_q     <= (ctrl.mode == DM_OCT);
			case (ctrl.mode)
				DM_DEC:  cnt_q <= DEC_DIGITS;
				DM_HEX:  cnt_q <= HEX_DIGITS;
				DM_OCT:  cnt_q <= OCT_DIGITS;
				default: cnt_q <= DEC_DIGITS;
			endcase
		end else if (ctrl.step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (emit) begin
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dig_q <= data;
		end else if (ctrl.step) begin
			dig_q <= oct_q ? {dig_q[DIG_W-4:0], 3'b0} : {dig_q[DIG_W-5:0], 4'b0};
		end
	end

	assign stat.digit = digit;
	assign stat.emit  = emit;
	assign stat.last  = (cnt_q == 4'd1);
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
	import i2a_pkg::*;

	// Commands 6 and 7 have no meaning: the block takes them and prints nothing.
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	// The slowest request is a decimal one, and a sender gap or a receiver
	// stall lengthens it. No correct run goes this long without a word
	// moving on either channel.
	localparam int QUIET_LIMIT = 4000;
	// Allow the last request to finish its work after the last character.
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_REQUESTS = 80;
	localparam int TAIL_REQUESTS = 20;

	typedef struct packed {
		logic [CHR_W-1:0] code;
		logic             last;
	} text_word_t;

	logic clk;
	logic arst_n;

	i2a_req_if req_if ();
	i2a_chr_if txt_if ();

	integer_to_ascii_formatter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_if),
		.text   (txt_if)
	);

	// Characters still owed by the block, oldest first.
	text_word_t expected_text[$];
	text_word_t want_word;

	int mismatch_count;
	int quiet_cycles;
	int stall_left;
	// Random gaps on the request side and stalls on the text side.
	logic idle_en;

	always #10 clk = ~clk;

	// Compute the text of one request, most significant character first, and
	// queue it with last set on the final character.
	function automatic void predict_text(input logic [CMD_W-1:0] cmd,
	                                     input logic [VAL_W-1:0] val);
		logic [CHR_W-1:0] line[$];
		logic [VAL_W-1:0] mag;
		int unsigned radix;
		int split;
		string glyphs;
		text_word_t w;
		glyphs = "0123456789ABCDEF";
		mag = val;
		radix = 0;
		case (cmd)
			CMD_LIT: begin
				// newline expands to newline plus carriage return
				line.push_back(val[CHR_W-1:0]);
				if (val[CHR_W-1:0] == CH_LF) begin
					line.push_back(CH_CR);
				end
			end
			CMD_RAW: begin
				line.push_back(val[CHR_W-1:0]);
			end
			CMD_SDEC: begin
				if (val[VAL_W-1]) begin
					line.push_back(CH_MINUS);
					mag = -val;
				end
				radix = 10;
			end
			CMD_UDEC: begin
				radix = 10;
			end
			CMD_HEX: begin
				line.push_back(CH_ZERO);
				line.push_back(CH_X);
				radix = 16;
			end
			CMD_OCT: begin
				// the leading zero alone stands for an octal zero
				line.push_back(CH_ZERO);
				radix = 8;
			end
			default: begin
			end
		endcase
		if (radix != 0) begin
			if (mag == 0 && radix != 8) begin
				line.push_back(CH_ZERO);
			end
			// insert each new digit in front of the ones already produced
			split = line.size();
			while (mag != 0) begin
				line.insert(split, glyphs[int'(mag % radix)]);
				mag = mag / radix;
			end
		end
		foreach (line[k]) begin
			w.code = line[k];
			w.last = (k == line.size() - 1);
			expected_text.push_back(w);
		end
	endfunction

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: mismatch: %s", $time, msg);
		end
	endtask

	// Offer one request word, with a random gap ahead of it when idling is on.
	// Valid stays high after acceptance; the next call either replaces the
	// payload or drops valid for a gap.
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.command <= cmd;
		req_if.value <= val;
		do @(posedge clk); while (!req_if.ready);
		predict_text(cmd, val);
	endtask

	// Drop valid and hold until every owed character has come back.
	task automatic hold_until_text_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] random_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = $urandom >> $urandom_range(1, 31);
			2: v = $urandom_range(0, 20);
			3: v = {24'($urandom), CH_LF};
			default: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = '1;
					2: v = {1'b1, {(VAL_W-1){1'b0}}};
					default: v = {1'b0, {(VAL_W-1){1'b1}}};
				endcase
			end
		endcase
		return v;
	endfunction

	// Pick a command; the spare ones come up now and then.
	function automatic logic [CMD_W-1:0] random_command();
		int r;
		r = $urandom_range(0, 19);
		if (r == 18) begin
			return CMD_SPARE_6;
		end else if (r == 19) begin
			return CMD_SPARE_7;
		end
		return CMD_W'(r % (CMD_OCT + 1));
	endfunction

	task automatic test_characters();
		send_request(CMD_LIT, 32'h0000_0041);
		send_request(CMD_LIT, {24'hABCDEF, CH_LF});
		send_request(CMD_LIT, 32'h0000_0000);
		send_request(CMD_LIT, 32'hFFFF_FFFF);
		send_request(CMD_RAW, {24'h000000, CH_LF});
		send_request(CMD_RAW, 32'hFFFF_FF80);
	endtask

	task automatic test_decimal();
		send_request(CMD_SDEC, 32'h0000_0000);
		send_request(CMD_SDEC, 32'h8000_0000);
		send_request(CMD_SDEC, 32'h7FFF_FFFF);
		send_request(CMD_SDEC, 32'hFFFF_FFFF);
		send_request(CMD_UDEC, 32'h0000_0000);
		send_request(CMD_UDEC, 32'hFFFF_FFFF);
		send_request(CMD_UDEC, 32'd7);
	endtask

	task automatic test_hex_octal();
		send_request(CMD_HEX, 32'h0000_0000);
		send_request(CMD_HEX, 32'hFFFF_FFFF);
		send_request(CMD_HEX, 32'h0000_ABCD);
		send_request(CMD_OCT, 32'h0000_0000);
		send_request(CMD_OCT, 32'hFFFF_FFFF);
		send_request(CMD_OCT, 32'd8);
	endtask

	// Spare commands must be swallowed without a character.
	task automatic test_spare_commands();
		send_request(CMD_SPARE_6, $urandom);
		send_request(CMD_SPARE_7, $urandom);
	endtask

	// Random mix, with gaps and stalls when idling is on; halfway, drain the
	// text channel fully before going on.
	task automatic test_random_mix(input int count);
		int done;
		logic [CMD_W-1:0] cmd;
		done = 0;
		while (done < count) begin
			cmd = random_command();
			send_request(cmd, random_value());
			if (cmd <= CMD_OCT) begin
				done++;
				if (done == count / 2) begin
					hold_until_text_drained();
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		idle_en = 1'b0;
		mismatch_count = 0;
		quiet_cycles = 0;
		stall_left = 0;
		req_if.valid = 1'b0;
		req_if.command = CMD_LIT;
		req_if.value = '0;
		txt_if.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed part runs with both sides always willing
		test_characters();
		test_decimal();
		test_hex_octal();
		test_spare_commands();
		hold_until_text_drained();

		idle_en = 1'b1;
		test_random_mix(RANDOM_REQUESTS - TAIL_REQUESTS);

		// last stretch runs back to back with no idling at all
		idle_en = 1'b0;
		test_random_mix(TAIL_REQUESTS);

		hold_until_text_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Receiver side: at random, hold ready low for a burst while idling is on.
	always @(negedge clk) begin
		if (!idle_en) begin
			stall_left <= 0;
			txt_if.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			txt_if.ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 15);
			txt_if.ready <= 1'b0;
		end else begin
			txt_if.ready <= 1'b1;
		end
	end

	// Check every accepted character against the oldest one owed.
	always @(posedge clk) begin
		if (txt_if.valid && txt_if.ready) begin
			if (expected_text.size() == 0) begin
				note_failure($sformatf("unexpected char %02h last %0b",
					txt_if.out_char, txt_if.last));
			end else begin
				want_word = expected_text.pop_front();
				if (txt_if.out_char !== want_word.code || txt_if.last !== want_word.last) begin
					note_failure($sformatf("char exp %02h got %02h, last exp %0b got %0b",
						want_word.code, txt_if.out_char, want_word.last, txt_if.last));
				end
			end
		end
	end

	// Watchdog: count cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (txt_if.valid && txt_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
